/* rtl/fpa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, codes and helpers for the signed fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int WORD_BITS     = 32;
  localparam int QUOT_BITS     = WORD_BITS + FRACTION_BITS;
  localparam int MAG_BITS      = 2 * WORD_BITS + 1;
  // front register + one cell per quotient bit + output register
  localparam int LATENCY       = QUOT_BITS + 2;

  typedef logic [WORD_BITS-1:0] word_t;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
    OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_TOINT, OP_FROMINT, OP_INC, OP_DEC
  } op_t;

  localparam logic [1:0] ST_OK  = 2'd0;
  localparam logic [1:0] ST_OVF = 2'd1;
  localparam logic [1:0] ST_DZ  = 2'd2;

  typedef struct packed {
    word_t      value;
    logic       flag;
    logic [1:0] status;
  } res_t;

  typedef struct packed {
    logic                 valid;
    logic                 is_div;
    logic                 neg;
    word_t                d;
    word_t                r;
    logic [QUOT_BITS-1:0] n;
    logic [QUOT_BITS-1:0] q;
    res_t                 res;
  } cell_t;

  function automatic word_t sat_word(logic neg);
    return neg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
  endfunction

  function automatic word_t mag_of(word_t x);
    return x[WORD_BITS-1] ? word_t'(0) - x : x;
  endfunction

  // sign and exact magnitude to a saturated word
  function automatic res_t saturate(logic neg, logic [MAG_BITS-1:0] mag);
    logic [MAG_BITS-1:0] limit;
    word_t               m;
    res_t                r;
    limit = neg ? (MAG_BITS'(1) << (WORD_BITS-1))
                : (MAG_BITS'(1) << (WORD_BITS-1)) - MAG_BITS'(1);
    m = mag[WORD_BITS-1:0];
    r.flag = 1'b0;
    if (mag > limit) begin
      r.value  = sat_word(neg);
      r.status = ST_OVF;
    end else begin
      r.value  = neg ? word_t'(0) - m : m;
      r.status = ST_OK;
    end
    return r;
  endfunction

  function automatic res_t add_sat(word_t a, word_t b, logic sub);
    word_t s;
    word_t ovf;
    res_t  r;
    s   = sub ? a - b : a + b;
    ovf = sub ? ((a ^ b) & (a ^ s)) : ((a ^ s) & (b ^ s));
    r.flag = 1'b0;
    if (ovf[WORD_BITS-1]) begin
      r.value  = sat_word(a[WORD_BITS-1]);
      r.status = ST_OVF;
    end else begin
      r.value  = s;
      r.status = ST_OK;
    end
    return r;
  endfunction

endpackage

/* rtl/fpa_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_cell
// One restoring-division cell: shifts in a dividend bit, makes one quotient
// bit, and hands the item to the next cell.
// ----------------------------------------------------------------------------
module fpa_cell (
  input  logic          clk,
  input  logic          rst_n,
  input  fpa_pkg::cell_t c_in,
  output fpa_pkg::cell_t c_out
);
  import fpa_pkg::*;

  cell_t              cell_r;
  cell_t              cell_nxt;
  logic [WORD_BITS:0] r2;
  logic [WORD_BITS:0] diff;
  logic               ge;

  always_comb begin
    r2   = {c_in.r, c_in.n[QUOT_BITS-1]};
    diff = r2 - {1'b0, c_in.d};
    ge   = r2 >= {1'b0, c_in.d};
    cell_nxt   = c_in;
    cell_nxt.r = ge ? diff[WORD_BITS-1:0] : r2[WORD_BITS-1:0];
    cell_nxt.n = {c_in.n[QUOT_BITS-2:0], 1'b0};
    cell_nxt.q = {c_in.q[QUOT_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.valid <= 1'b0;
    end else begin
      cell_r.valid <= cell_nxt.valid;
    end
    cell_r.is_div <= cell_nxt.is_div;
    cell_r.neg    <= cell_nxt.neg;
    cell_r.d      <= cell_nxt.d;
    cell_r.r      <= cell_nxt.r;
    cell_r.n      <= cell_nxt.n;
    cell_r.q      <= cell_nxt.q;
    cell_r.res    <= cell_nxt.res;
  end

  assign c_out = cell_r;

endmodule

/* rtl/fpa_finish.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_finish
// Rounds the quotient from the last cell and saturates it; other items
// pass their result through.
// ----------------------------------------------------------------------------
module fpa_finish (
  input  fpa_pkg::cell_t c_in,
  output fpa_pkg::res_t  res
);
  import fpa_pkg::*;

  logic             rnd;
  logic [QUOT_BITS:0] qr;

  always_comb begin
    // round half away from zero: 2r >= d
    rnd = {c_in.r, 1'b0} >= {1'b0, c_in.d};
    qr  = {1'b0, c_in.q} + {{QUOT_BITS{1'b0}}, rnd};
    if (c_in.is_div) begin
      res = saturate(c_in.neg, MAG_BITS'(qr));
    end else begin
      res = c_in.res;
    end
  end

endmodule

/* rtl/fixed_point_alu.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q24.8 ALU. Every operation passes through the front register, the
// 40-cell division chain and the output register on its way to out_valid.
// Throughput: one item per cycle; busy stays low, the receiver cannot stall.
// Reset: synchronous active-low rst_n clears all item valid bits.
// ----------------------------------------------------------------------------
module fixed_point_alu (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [3:0]                       in_operation,
  input  logic signed [fpa_pkg::WORD_BITS-1:0] in_operand_a,
  input  logic signed [fpa_pkg::WORD_BITS-1:0] in_operand_b,
  output logic                             out_valid,
  output logic signed [fpa_pkg::WORD_BITS-1:0] out_value,
  output logic                             out_flag,
  output logic [1:0]                       out_status
);
  import fpa_pkg::*;

  typedef struct packed {
    logic                   valid;
    logic                   is_div;
    logic                   is_mul;
    logic                   neg;
    word_t                  ma;
    word_t                  mb;
    logic [2*WORD_BITS-1:0] prod;
    res_t                   res;
  } front_t;

  front_t front_r;
  front_t front_nxt;
  word_t  a;
  word_t  b;
  logic   gt;
  logic   lt;
  word_t  t;
  cell_t  chain [QUOT_BITS+1];
  res_t   fin;
  res_t   mul_res;
  logic [MAG_BITS-1:0] mul_sum;
  logic   out_valid_r;
  res_t   out_r;

  assign busy = 1'b0;

  always_comb begin
    a  = word_t'(in_operand_a);
    b  = word_t'(in_operand_b);
    gt = $signed(a) > $signed(b);
    lt = $signed(b) > $signed(a);
    t  = mag_of(a) >> FRACTION_BITS;
    front_nxt.valid  = start;
    front_nxt.is_div = 1'b0;
    front_nxt.is_mul = 1'b0;
    front_nxt.neg    = a[WORD_BITS-1] ^ b[WORD_BITS-1];
    front_nxt.ma     = mag_of(a);
    front_nxt.mb     = mag_of(b);
    front_nxt.prod   = {{WORD_BITS{1'b0}}, mag_of(a)} * {{WORD_BITS{1'b0}}, mag_of(b)};
    front_nxt.res    = '{value: '0, flag: 1'b0, status: ST_OK};
    case (op_t'(in_operation))
      OP_ADD: front_nxt.res = add_sat(a, b, 1'b0);
      OP_SUB: front_nxt.res = add_sat(a, b, 1'b1);
      OP_MUL: front_nxt.is_mul = 1'b1;
      OP_DIV: begin
        if (b == '0) begin
          front_nxt.res = '{value: sat_word(a[WORD_BITS-1]), flag: 1'b0, status: ST_DZ};
        end else begin
          front_nxt.is_div = 1'b1;
        end
      end
      OP_GT: front_nxt.res.flag = gt;
      OP_LT: front_nxt.res.flag = lt;
      OP_GE: front_nxt.res.flag = !lt;
      OP_LE: front_nxt.res.flag = !gt;
      OP_EQ: front_nxt.res.flag = (a == b);
      OP_NE: front_nxt.res.flag = (a != b);
      OP_MIN: front_nxt.res.value = gt ? b : a;
      OP_MAX: front_nxt.res.value = gt ? a : b;
      OP_TOINT: front_nxt.res.value = a[WORD_BITS-1] ? word_t'(0) - t : t;
      OP_FROMINT: front_nxt.res = saturate(a[WORD_BITS-1],
                    MAG_BITS'({mag_of(a), {FRACTION_BITS{1'b0}}}));
      OP_INC: front_nxt.res = add_sat(a, word_t'(1), 1'b0);
      OP_DEC: front_nxt.res = add_sat(a, word_t'(1), 1'b1);
      default: front_nxt.res = add_sat(a, word_t'(1), 1'b1);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r.valid <= 1'b0;
    end else begin
      front_r.valid <= front_nxt.valid;
    end
    front_r.is_div <= front_nxt.is_div;
    front_r.is_mul <= front_nxt.is_mul;
    front_r.neg    <= front_nxt.neg;
    front_r.ma     <= front_nxt.ma;
    front_r.mb     <= front_nxt.mb;
    front_r.prod   <= front_nxt.prod;
    front_r.res    <= front_nxt.res;
  end

  // multiply rounding folds into the item entering the chain
  always_comb begin
    mul_sum = {1'b0, front_r.prod} + (MAG_BITS'(1) << (FRACTION_BITS-1));
    mul_res = saturate(front_r.neg, mul_sum >> FRACTION_BITS);
    chain[0].valid  = front_r.valid;
    chain[0].is_div = front_r.is_div;
    chain[0].neg    = front_r.neg;
    chain[0].d      = front_r.mb;
    chain[0].r      = '0;
    chain[0].n      = {front_r.ma, {FRACTION_BITS{1'b0}}};
    chain[0].q      = '0;
    chain[0].res    = front_r.is_mul ? mul_res : front_r.res;
  end

  for (genvar i = 0; i < QUOT_BITS; i++) begin : g_cell
    fpa_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .c_in  (chain[i]),
      .c_out (chain[i+1])
    );
  end

  fpa_finish u_finish (
    .c_in (chain[QUOT_BITS]),
    .res  (fin)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain[QUOT_BITS].valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= fin;
  end

  assign out_valid  = out_valid_r;
  assign out_value  = out_r.value;
  assign out_flag   = out_r.flag;
  assign out_status = out_r.status;

endmodule

/* rtl/fpa_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks for the fixed-point ALU.
// ----------------------------------------------------------------------------
module fpa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic       out_flag,
  input logic [1:0] out_status
);
  import fpa_pkg::*;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("item result missing at fixed latency");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start, LATENCY))
    else $error("result without an accepted item");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_OK || out_status == ST_OVF || out_status == ST_DZ))
    else $error("bad status code");

  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_OK) |-> !out_flag)
    else $error("flag set on an arithmetic fault");

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_valid  (out_valid),
  .out_flag   (out_flag),
  .out_status (out_status)
);
